/* hw/rtl/pba_pkg.sv */
// Shared types and codes for the power-of-two bucket allocator.
// Depends on nothing; used by pba_ctrl, pba_datapath and the top level.
`timescale 1ns / 1ps
package pba_pkg;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_FREE   = 2'd1,
    MODE_RESIZE = 2'd2,
    MODE_NONE   = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_BIG     = 2'd1,
    ST_OOM     = 2'd2,
    ST_BADFREE = 2'd3
  } status_t;

  localparam logic CFG_HEAP_BASE  = 1'b0;
  localparam logic CFG_HEAP_LIMIT = 1'b1;

  typedef struct packed {
    logic [1:0]  mode;
    logic [14:0] req_size;
    logic [15:0] block_addr;
  } in_t;

  typedef struct packed {
    logic [15:0] result_addr;
    logic [3:0]  bucket;
    logic [14:0] capacity;
    logic [1:0]  status;
  } out_t;

  // One block header word.
  typedef struct packed {
    logic        nextv;
    logic        inuse;
    logic        carved;
    logic [3:0]  bkt;
    logic [15:0] next;
  } hdr_t;

  typedef struct packed {
    logic    latch;
    logic    clr_step;
    logic    rd_blk;
    logic    rd_head;
    logic    free_q;
    logic    free_old;
    logic    cap_old;
    logic    pop;
    logic    clr_head_v;
    logic    carve;
    logic    res_fit;
    logic    res_zero;
    logic    res_err;
    status_t res_code;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  p_zero;
    logic  size_ok;
    logic  head_v;
    logic  blk_ok;
    logic  live;
    logic  fits;
    logic  head_ok;
    logic  carve_ok;
    logic  clr_last;
    logic  base_wr;
  } dp_stat_t;

endpackage

/* hw/rtl/pba_datapath.sv */
// Datapath of the bucket allocator: config registers, list heads, break
// pointer, header memory and result registers. Depends on pba_pkg.
`timescale 1ns / 1ps
module pba_datapath #(
  parameter int NUM_BUCKETS  = 8,
  parameter int MIN_CAPACITY = 8,
  parameter int HEADER_BYTES = 6,
  parameter int HEAP_BYTES   = 16384
) (
  input  logic             clk,
  input  logic             rst_n,
  input  pba_pkg::in_t     in_data,
  input  logic             cfg_valid,
  input  logic             cfg_ready,
  input  logic             cfg_index,
  input  logic [15:0]      cfg_data,
  input  pba_pkg::dp_cmd_t cmd,
  output pba_pkg::dp_stat_t stat,
  output pba_pkg::out_t    out_data
);
  import pba_pkg::*;

  localparam int AW = $clog2(HEAP_BYTES);
  localparam int BW = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
  localparam logic [AW-1:0] LAST_IDX = AW'(HEAP_BYTES - 1);
  localparam logic [15:0] HDR16 = 16'(HEADER_BYTES);
  localparam logic [16:0] HEAP17 = 17'(HEAP_BYTES);

  logic [15:0] base_r, limit_r, break_r;
  logic [15:0] heads_r [NUM_BUCKETS];
  logic [NUM_BUCKETS-1:0] head_v_r;
  logic [AW-1:0] clr_cnt_r;
  hdr_t mem [HEAP_BYTES];
  hdr_t q_r, old_r;
  in_t req_r;
  out_t res_r;

  logic base_wr;
  assign base_wr = cfg_valid & cfg_ready & (cfg_index == CFG_HEAP_BASE);

  function automatic logic [23:0] cap_of(logic [3:0] b);
    return 24'(MIN_CAPACITY) << b;
  endfunction

  function automatic logic [14:0] sat15(logic [23:0] c);
    return (c > 24'd32767) ? 15'h7FFF : c[14:0];
  endfunction

  // Bucket of the requested size: lowest bucket whose capacity holds it.
  logic [3:0]  ab;
  logic        size_ok;
  always_comb begin
    ab = '0;
    size_ok = 1'b0;
    for (int i = NUM_BUCKETS - 1; i >= 0; i--) begin
      if ({9'd0, req_r.req_size} <= cap_of(4'(i))) begin
        ab = 4'(i);
        size_ok = 1'b1;
      end
    end
  end
  logic [23:0] acap;
  assign acap = cap_of(ab);

  // Bucket of the block being freed, clamped to the last bucket.
  hdr_t fw;
  logic [3:0] fb;
  assign fw = cmd.free_q ? q_r : old_r;
  assign fb = (fw.bkt >= 4'(NUM_BUCKETS)) ? 4'(NUM_BUCKETS - 1) : fw.bkt;

  logic [BW-1:0] hsel;
  logic [15:0] head;
  logic head_valid;
  assign hsel = (cmd.free_q | cmd.free_old) ? fb[BW-1:0] : ab[BW-1:0];
  assign head = heads_r[hsel];
  assign head_valid = head_v_r[hsel];

  logic [15:0] blk_off, head_off, brk_off;
  assign blk_off  = req_r.block_addr - HDR16 - base_r;
  assign head_off = head - base_r;
  assign brk_off  = break_r - base_r;

  logic [15:0] blk_hdr;
  assign blk_hdr = req_r.block_addr - HDR16;

  logic [23:0] carve_end, heap_end;
  assign carve_end = {8'd0, break_r} + acap + 24'(HEADER_BYTES);
  assign heap_end  = {8'd0, base_r} + 24'(HEAP_BYTES);

  always_comb begin
    stat.mode     = mode_t'(req_r.mode);
    stat.p_zero   = (req_r.block_addr == 16'd0);
    stat.size_ok  = size_ok;
    stat.head_v   = head_v_r[ab[BW-1:0]];
    stat.blk_ok   = ({1'b0, blk_off} < HEAP17);
    stat.live     = q_r.carved & q_r.inuse;
    stat.fits     = ({9'd0, req_r.req_size} <= cap_of(q_r.bkt));
    stat.head_ok  = ({1'b0, head_off} < HEAP17);
    stat.carve_ok = (carve_end <= {8'd0, limit_r}) && (carve_end <= heap_end);
    stat.clr_last = (clr_cnt_r == LAST_IDX);
    stat.base_wr  = base_wr;
  end

  // Header memory: one write and one registered read a cycle.
  logic          we, re;
  logic [AW-1:0] wa, ra;
  hdr_t          wd, free_word, alloc_word;
  always_comb begin
    alloc_word = '{nextv: 1'b0, inuse: 1'b1, carved: 1'b1, bkt: ab, next: '0};
    free_word  = '{nextv: head_valid, inuse: 1'b0, carved: 1'b1, bkt: fb,
                   next: head_valid ? head : 16'd0};
    we = 1'b0;
    wa = clr_cnt_r;
    wd = '0;
    ra = cmd.rd_blk ? blk_off[AW-1:0] : head_off[AW-1:0];
    re = cmd.rd_blk | cmd.rd_head;
    if (cmd.clr_step) begin
      we = 1'b1;
    end else if (cmd.pop) begin
      we = 1'b1;
      wa = head_off[AW-1:0];
      wd = alloc_word;
    end else if (cmd.carve) begin
      we = 1'b1;
      wa = brk_off[AW-1:0];
      wd = alloc_word;
    end else if (cmd.free_q) begin
      we = 1'b1;
      wa = blk_off[AW-1:0];
      wd = free_word;
    end else if (cmd.free_old) begin
      we = 1'b1;
      wa = blk_off[AW-1:0];
      wd = free_word;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      q_r <= mem[ra];
    end
    if (cmd.cap_old) begin
      old_r <= q_r;
    end
    if (cmd.latch) begin
      req_r <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r    <= '0;
      limit_r   <= 16'hFFFF;
      break_r   <= '0;
      head_v_r  <= '0;
      clr_cnt_r <= '0;
    end else if (base_wr) begin
      base_r    <= cfg_data;
      break_r   <= cfg_data;
      head_v_r  <= '0;
      clr_cnt_r <= '0;
    end else begin
      if (cfg_valid && cfg_ready && cfg_index == CFG_HEAP_LIMIT) begin
        limit_r <= cfg_data;
      end
      if (cmd.clr_step) begin
        clr_cnt_r <= clr_cnt_r + 1'b1;
      end
      if (cmd.pop) begin
        head_v_r[ab[BW-1:0]] <= q_r.nextv;
      end else if (cmd.clr_head_v) begin
        head_v_r[ab[BW-1:0]] <= 1'b0;
      end else if (cmd.free_q || cmd.free_old) begin
        head_v_r[fb[BW-1:0]] <= 1'b1;
      end
      if (cmd.carve) begin
        break_r <= carve_end[15:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      heads_r[ab[BW-1:0]] <= q_r.next;
    end else if (cmd.free_q || cmd.free_old) begin
      heads_r[fb[BW-1:0]] <= blk_hdr;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.pop) begin
      res_r <= '{result_addr: head + HDR16, bucket: ab, capacity: sat15(acap),
                 status: ST_OK};
    end else if (cmd.carve) begin
      res_r <= '{result_addr: break_r + HDR16, bucket: ab, capacity: sat15(acap),
                 status: ST_OK};
    end else if (cmd.free_q) begin
      res_r <= '{result_addr: 16'd0, bucket: fb, capacity: sat15(cap_of(fb)),
                 status: ST_OK};
    end else if (cmd.res_fit) begin
      res_r <= '{result_addr: req_r.block_addr, bucket: q_r.bkt,
                 capacity: sat15(cap_of(q_r.bkt)), status: ST_OK};
    end else if (cmd.res_zero) begin
      res_r <= '0;
    end else if (cmd.res_err) begin
      if (cmd.res_code == ST_OOM) begin
        res_r <= '{result_addr: 16'd0, bucket: ab, capacity: sat15(acap),
                   status: ST_OOM};
      end else begin
        res_r <= '{result_addr: 16'd0, bucket: 4'd0, capacity: 15'd0,
                   status: cmd.res_code};
      end
    end
  end

  assign out_data = res_r;

endmodule

/* hw/rtl/pba_ctrl.sv */
// Controller state machine of the bucket allocator.
// Depends on pba_pkg; drives pba_datapath through command and status structs.
`timescale 1ns / 1ps
module pba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  pba_pkg::dp_stat_t stat,
  output pba_pkg::dp_cmd_t  cmd,
  output logic              busy,
  output logic              out_valid
);
  import pba_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CLEAR  = 9'b000000010,
    S_DECODE = 9'b000000100,
    S_FCHK   = 9'b000001000,
    S_RCHK   = 9'b000010000,
    S_POP    = 9'b000100000,
    S_CARVE  = 9'b001000000,
    S_RFREE  = 9'b010000000,
    S_DONE   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;
  logic is_alloc, is_resize;

  assign is_resize = (stat.mode == MODE_RESIZE);
  assign is_alloc  = (stat.mode == MODE_ALLOC) || (is_resize && stat.p_zero);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.res_code = ST_OK;
    unique case (state_r)
      S_IDLE: begin
        if (stat.base_wr) begin
          state_nxt = S_CLEAR;
        end else if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DECODE;
        end
      end
      S_CLEAR: begin
        if (!stat.base_wr) begin
          cmd.clr_step = 1'b1;
          if (stat.clr_last) state_nxt = S_IDLE;
        end
      end
      S_DECODE: begin
        state_nxt = S_DONE;
        if (is_alloc) begin
          if (!stat.size_ok) begin
            cmd.res_err = 1'b1;
            cmd.res_code = ST_BIG;
          end else if (stat.head_v) begin
            cmd.rd_head = 1'b1;
            state_nxt = S_POP;
          end else begin
            state_nxt = S_CARVE;
          end
        end else if (stat.mode == MODE_FREE) begin
          if (stat.p_zero) begin
            cmd.res_zero = 1'b1;
          end else if (!stat.blk_ok) begin
            cmd.res_err = 1'b1;
            cmd.res_code = ST_BADFREE;
          end else begin
            cmd.rd_blk = 1'b1;
            state_nxt = S_FCHK;
          end
        end else if (is_resize) begin
          if (!stat.blk_ok) begin
            cmd.res_err = 1'b1;
            cmd.res_code = ST_BADFREE;
          end else begin
            cmd.rd_blk = 1'b1;
            state_nxt = S_RCHK;
          end
        end else begin
          cmd.res_zero = 1'b1;
        end
      end
      S_FCHK: begin
        state_nxt = S_DONE;
        if (stat.live) begin
          cmd.free_q = 1'b1;
        end else begin
          cmd.res_err = 1'b1;
          cmd.res_code = ST_BADFREE;
        end
      end
      S_RCHK: begin
        state_nxt = S_DONE;
        cmd.cap_old = 1'b1;
        if (!stat.live) begin
          cmd.res_err = 1'b1;
          cmd.res_code = ST_BADFREE;
        end else if (stat.fits) begin
          cmd.res_fit = 1'b1;
        end else if (!stat.size_ok) begin
          cmd.res_err = 1'b1;
          cmd.res_code = ST_BIG;
        end else if (stat.head_v) begin
          cmd.rd_head = 1'b1;
          state_nxt = S_POP;
        end else begin
          state_nxt = S_CARVE;
        end
      end
      S_POP: begin
        // A head outside the heap is dropped and the block is carved instead.
        if (stat.head_ok) begin
          cmd.pop = 1'b1;
          state_nxt = (is_resize && !stat.p_zero) ? S_RFREE : S_DONE;
        end else begin
          cmd.clr_head_v = 1'b1;
          state_nxt = S_CARVE;
        end
      end
      S_CARVE: begin
        if (stat.carve_ok) begin
          cmd.carve = 1'b1;
          state_nxt = (is_resize && !stat.p_zero) ? S_RFREE : S_DONE;
        end else begin
          cmd.res_err = 1'b1;
          cmd.res_code = ST_OOM;
          state_nxt = S_DONE;
        end
      end
      S_RFREE: begin
        cmd.free_old = 1'b1;
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = (state_r == S_DONE);

endmodule

/* hw/rtl/pow2_bucket_allocator.sv */
// Top level of the power-of-two bucket allocator.
// Depends on pba_pkg, pba_ctrl and pba_datapath.
`timescale 1ns / 1ps
// A request is taken when start is high and busy is low. Its single result
// appears for one cycle with out_valid and cannot be held off. Some requests
// are rejected at decode and go straight to the result: a size too big, a
// free or resize of an address outside the heap, a free of address zero,
// and the unused mode. An allocate from a free list, a free and a resize
// that fits read the header memory at decode and use the registered word
// in the pop or check state; an allocate from the break pointer carves in
// the state after decode. A resize that runs out of memory checks the old
// block and then fails to carve. A resize that moves the block allocates
// and then frees the old block. Busy stays high while the result is shown,
// so the next request is taken in the cycle after the result at the
// earliest. After reset and after every heap_base write the header memory
// is cleared one entry a cycle, all HEAP_BYTES entries, with busy high.
// Configuration writes are taken only while the block is idle and no
// request is offered.
module pow2_bucket_allocator #(
  parameter int NUM_BUCKETS  = 8,
  parameter int MIN_CAPACITY = 8,
  parameter int HEADER_BYTES = 6,
  parameter int HEAP_BYTES   = 16384
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  pba_pkg::in_t  in_data,
  output logic          out_valid,
  output pba_pkg::out_t out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic          cfg_index,
  input  logic [15:0]   cfg_data
);
  import pba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // A write must not land while a request is in flight or being taken.
  assign cfg_ready = ~busy & ~start;

  pba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (stat),
    .cmd       (cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  pba_datapath #(
    .NUM_BUCKETS  (NUM_BUCKETS),
    .MIN_CAPACITY (MIN_CAPACITY),
    .HEADER_BYTES (HEADER_BYTES),
    .HEAP_BYTES   (HEAP_BYTES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

/* tb/tb_pow2_bucket_allocator.sv */
// Self-checking testbench for pow2_bucket_allocator: directed and random
// allocate, free and resize requests against an in-bench allocator model.
// Depends on pba_pkg and the pow2_bucket_allocator RTL.
`timescale 1ns / 1ps
module tb_pow2_bucket_allocator;
  import pba_pkg::*;

  localparam int NB       = 8;
  localparam int MIN_CAP  = 8;
  localparam int HDR      = 6;
  localparam int HEAP     = 16384;
  // Covers the header clearing pass after reset or a heap_base write.
  localparam int IDLE_LIMIT = 4 * HEAP;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  in_t         in_data = '0;
  logic        out_valid;
  out_t        out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = 1'b0;
  logic [15:0] cfg_data = '0;

  pow2_bucket_allocator u_dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Allocator model state.
  logic [15:0] base_m, limit_m;
  logic [15:0] list_head [NB];
  logic        list_head_v [NB];
  int unsigned brk_m;
  hdr_t        hdr_mem [HEAP];

  out_t        expected_q[$];
  logic [15:0] live_blocks[$];
  logic [15:0] freed_blocks[$];
  int          errors = 0;
  int          idle_cycles = 0;

  function automatic void clear_heap();
    for (int i = 0; i < NB; i++) begin
      list_head[i] = '0;
      list_head_v[i] = 1'b0;
    end
    for (int i = 0; i < HEAP; i++) hdr_mem[i] = '0;
    brk_m = 32'(base_m);
    live_blocks.delete();
    freed_blocks.delete();
  endfunction

  function automatic void forget_block(input logic [15:0] a);
    for (int i = 0; i < live_blocks.size(); i++) begin
      if (live_blocks[i] == a) begin
        live_blocks.delete(i);
        break;
      end
    end
    freed_blocks.push_back(a);
    if (freed_blocks.size() > 16) void'(freed_blocks.pop_front());
  endfunction

  function automatic status_t take_block(input int unsigned n, output logic [15:0] addr,
                                         output logic [3:0] bk, output logic [14:0] cap);
    int b;
    int unsigned c, endp, off;
    logic [15:0] h;
    hdr_t w;
    addr = '0; bk = '0; cap = '0;
    b = -1;
    c = MIN_CAP;
    for (int i = 0; i < NB; i++) begin
      if (b < 0) begin
        if (n <= c) b = i;
        else c = c + c;
      end
    end
    if (b < 0) return ST_BIG;
    bk = b[3:0];
    cap = c[14:0];
    w = '0;
    w.carved = 1'b1;
    w.inuse = 1'b1;
    w.bkt = b[3:0];
    if (list_head_v[b]) begin
      h = list_head[b];
      off = 32'(16'(h - base_m));
      if (off < HEAP) begin
        list_head[b] = hdr_mem[off].next;
        list_head_v[b] = hdr_mem[off].nextv;
        hdr_mem[off] = w;
        addr = h + 16'(HDR);
        return ST_OK;
      end
      list_head_v[b] = 1'b0;
    end
    endp = brk_m + c + HDR;
    if (endp > limit_m || endp > base_m + HEAP) return ST_OOM;
    off = brk_m - base_m;
    hdr_mem[off] = w;
    addr = 16'(brk_m + HDR);
    brk_m = endp;
    return ST_OK;
  endfunction

  function automatic bit block_live(input logic [15:0] u, output int unsigned idx);
    logic [15:0] h, off;
    h = u - 16'(HDR);
    off = h - base_m;
    idx = 32'(off);
    if (off >= HEAP) return 1'b0;
    return hdr_mem[off].carved && hdr_mem[off].inuse;
  endfunction

  function automatic void release_block(input int unsigned idx, output logic [3:0] bk,
                                        output logic [14:0] cap);
    logic [3:0] b;
    hdr_t w;
    b = hdr_mem[idx].bkt;
    if (b >= NB) b = 4'(NB - 1);
    w = '0;
    w.carved = 1'b1;
    w.bkt = b;
    if (list_head_v[b]) begin
      w.nextv = 1'b1;
      w.next = list_head[b];
    end
    hdr_mem[idx] = w;
    list_head[b] = 16'(idx + base_m);
    list_head_v[b] = 1'b1;
    bk = b;
    cap = 15'(MIN_CAP << b);
  endfunction

  // Expected result of one request; also tracks which addresses are live.
  function automatic out_t serve_request(input in_t req);
    out_t r;
    int unsigned idx;
    logic [3:0] ob, fb;
    logic [14:0] oc, fc;
    r = '0;
    if (req.mode == MODE_ALLOC || (req.mode == MODE_RESIZE && req.block_addr == 0)) begin
      r.status = take_block(req.req_size, r.result_addr, r.bucket, r.capacity);
      if (r.status == ST_OK) live_blocks.push_back(r.result_addr);
    end else if (req.mode == MODE_FREE) begin
      if (req.block_addr != 0) begin
        if (block_live(req.block_addr, idx)) begin
          release_block(idx, fb, fc);
          r.bucket = fb;
          r.capacity = fc;
          forget_block(req.block_addr);
        end else begin
          r.status = ST_BADFREE;
        end
      end
    end else if (req.mode == MODE_RESIZE) begin
      if (!block_live(req.block_addr, idx)) begin
        r.status = ST_BADFREE;
      end else begin
        ob = hdr_mem[idx].bkt;
        oc = 15'(MIN_CAP << ob);
        if (req.req_size <= oc) begin
          r.result_addr = req.block_addr;
          r.bucket = ob;
          r.capacity = oc;
        end else begin
          r.status = take_block(req.req_size, r.result_addr, r.bucket, r.capacity);
          if (r.status == ST_OK) begin
            release_block(idx, fb, fc);
            forget_block(req.block_addr);
            live_blocks.push_back(r.result_addr);
          end
        end
      end
    end
    if (r.status == ST_BIG || r.status == ST_BADFREE) begin
      r.result_addr = '0;
      r.bucket = '0;
      r.capacity = '0;
    end
    return r;
  endfunction

  // Inputs change at the falling edge; a beat is taken at the next rising edge.
  task automatic send_request(input in_t req);
    @(negedge clk);
    while (busy) begin
      start <= 1'b0;
      @(negedge clk);
    end
    start <= 1'b1;
    in_data <= req;
    @(posedge clk);
    expected_q.push_back(serve_request(req));
  endtask

  task automatic idle_gap(input bit quiet);
    int r, n;
    r = $urandom_range(0, 99);
    n = quiet ? 0 : (r < 55 ? 0 : (r < 92 ? $urandom_range(1, 3) : $urandom_range(10, 40)));
    repeat (n) begin
      @(negedge clk);
      start <= 1'b0;
    end
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [15:0] val);
    wait_drained();
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == CFG_HEAP_BASE) begin
      base_m = val;
      clear_heap();
    end else begin
      limit_m = val;
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic in_t make_request(input mode_t m, input int unsigned n,
                                       input logic [15:0] a);
    in_t q;
    q.mode = m;
    q.req_size = n[14:0];
    q.block_addr = a;
    return q;
  endfunction

  function automatic logic [15:0] pick_addr();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70 && live_blocks.size() != 0)
      return live_blocks[$urandom_range(0, live_blocks.size() - 1)];
    if (r < 82 && freed_blocks.size() != 0)
      return freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
    if (r < 90) return '0;
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic int unsigned pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 64);
    if (r < 85) return $urandom_range(0, 1024);
    if (r < 93) return $urandom_range(1000, 1100);
    return $urandom_range(0, 32767);
  endfunction

  task automatic random_requests(input int count);
    int r;
    bit quiet;
    mode_t m;
    quiet = 1'b0;
    for (int i = 0; i < count; i++) begin
      if (i % 50 == 0) quiet = ($urandom_range(0, 3) == 0);
      r = $urandom_range(0, 99);
      m = r < 40 ? MODE_ALLOC : (r < 70 ? MODE_FREE : (r < 96 ? MODE_RESIZE : MODE_NONE));
      send_request(make_request(m, pick_size(), pick_addr()));
      idle_gap(quiet);
    end
  endtask

  task automatic test_directed();
    logic [15:0] a;
    send_request(make_request(MODE_ALLOC, 0, 16'h0000));
    send_request(make_request(MODE_ALLOC, 8, 16'hFFFF));
    send_request(make_request(MODE_ALLOC, 9, 16'h0000));
    send_request(make_request(MODE_ALLOC, 1024, 16'h0000));
    send_request(make_request(MODE_ALLOC, 1025, 16'h0000));
    send_request(make_request(MODE_ALLOC, 32767, 16'h0000));
    send_request(make_request(MODE_FREE, 0, 16'h0000));
    a = live_blocks[1];
    send_request(make_request(MODE_FREE, 5, a));
    send_request(make_request(MODE_FREE, 0, a));
    send_request(make_request(MODE_FREE, 0, 16'hFFFF));
    send_request(make_request(MODE_FREE, 0, 16'h0003));
    send_request(make_request(MODE_ALLOC, 7, 16'h0000));
    send_request(make_request(MODE_RESIZE, 20, 16'h0000));
    a = live_blocks[live_blocks.size() - 1];
    send_request(make_request(MODE_RESIZE, 32, a));
    send_request(make_request(MODE_RESIZE, 500, a));
    send_request(make_request(MODE_RESIZE, 10, a));
    send_request(make_request(MODE_RESIZE, 2000, live_blocks[0]));
    send_request(make_request(MODE_NONE, 32767, 16'hFFFF));
    send_request(make_request(MODE_NONE, 0, 16'h0000));
  endtask

  task automatic test_default_heap();
    random_requests(500);
  endtask

  // A small limit makes carving run out, including during resize growth.
  task automatic test_tight_limit();
    write_reg(CFG_HEAP_BASE, 16'h1000);
    write_reg(CFG_HEAP_LIMIT, 16'h1000 + 16'd700);
    send_request(make_request(MODE_ALLOC, 300, 16'h0000));
    send_request(make_request(MODE_RESIZE, 600, live_blocks[0]));
    send_request(make_request(MODE_RESIZE, 1024, live_blocks[0]));
    random_requests(300);
  endtask

  task automatic test_high_base();
    write_reg(CFG_HEAP_LIMIT, 16'hFFFF);
    write_reg(CFG_HEAP_BASE, 16'hBFF0);
    random_requests(300);
  endtask

  task automatic test_extremes();
    write_reg(CFG_HEAP_BASE, 16'hFFFF);
    write_reg(CFG_HEAP_LIMIT, 16'h0000);
    random_requests(30);
    write_reg(CFG_HEAP_LIMIT, 16'hFFFF);
    random_requests(20);
    write_reg(CFG_HEAP_BASE, 16'h0000);
    random_requests(60);
  endtask

  // Each result is checked against the oldest pending expectation.
  always @(posedge clk) begin
    out_t e;
    if (rst_n && out_valid) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result beat %h", out_data);
        errors++;
      end else begin
        e = expected_q.pop_front();
        if (out_data.result_addr !== e.result_addr) begin
          $error("result_addr expected %h actual %h", e.result_addr, out_data.result_addr);
          errors++;
        end
        if (out_data.bucket !== e.bucket) begin
          $error("bucket expected %0d actual %0d", e.bucket, out_data.bucket);
          errors++;
        end
        if (out_data.capacity !== e.capacity) begin
          $error("capacity expected %0d actual %0d", e.capacity, out_data.capacity);
          errors++;
        end
        if (out_data.status !== e.status) begin
          $error("status expected %0d actual %0d", e.status, out_data.status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    base_m = '0;
    limit_m = 16'hFFFF;
    clear_heap();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_default_heap();
    test_tight_limit();
    test_high_base();
    test_extremes();
    wait_drained();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/pba_pkg.sv
hw/rtl/pba_datapath.sv
hw/rtl/pba_ctrl.sv
hw/rtl/pow2_bucket_allocator.sv
tb/tb_pow2_bucket_allocator.sv
